### rtl/gregorian_date_info_unit_defines.svh
// Assertion macros for the Gregorian date info unit.
`ifndef GREGORIAN_DATE_INFO_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_INFO_UNIT_DEFINES_SVH

`ifndef SYNTH
`define GDI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdi assertion failed");
`define GDI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdi assertion failed");
`else
`define GDI_ASSERT_NOW(lbl, ante, cons)
`define GDI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/gdi_pkg.sv
// Shared types, constants and calendar tables of the Gregorian date info unit.
package gdi_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int ShYearW = 15;  // year + 400, minus one for Jan/Feb

  // floor(x / 25) = (x * Recip25) >> RecipShift, exact for x below 4200
  localparam logic [10:0] Recip25    = 11'd1311;
  localparam int          RecipShift = 15;

  localparam logic [3:0] MonthFeb = 4'd2;

  typedef struct packed {
    logic [ShYearW-1:0] y;        // shifted year for the weekday sum
    logic [11:0]        yq;       // year >> 2
    logic               div4;     // year divisible by 4
    logic [23:0]        py;       // (y >> 2) * Recip25
    logic [22:0]        pyr;      // (year >> 2) * Recip25
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
  } s1_t;

  typedef struct packed {
    logic [ShYearW-1:0] s;        // weekday sum before mod 7
    logic               leap;
    logic [4:0]         mlen;
    logic               invalid;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
  } s2_t;

  typedef struct packed {
    logic [2:0] wd;
    logic [4:0] to_mend;
    logic [8:0] to_yend;
    logic       leap;
    logic [4:0] mlen;
    logic       invalid;
  } s3_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      MonthFeb:                                    r = leap ? 5'd29 : 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

  // (31 * m) / 12 with m counted from March as 1
  function automatic logic [4:0] month_offset(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd2;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd7;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd12;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd23;
      4'd12:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/gdi_decode.sv
// Stage 1: shift the year and start both divisions by 100.
module gdi_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [gdi_pkg::YearW-1:0] year,
  input  logic [gdi_pkg::MonthW-1:0] month,
  input  logic [gdi_pkg::DayW-1:0]  day,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output gdi_pkg::s1_t              dn_data
);

  logic                        valid_r;
  gdi_pkg::s1_t                data_r;
  gdi_pkg::s1_t                data_nxt;
  logic                        jan_feb;
  logic [gdi_pkg::ShYearW-1:0] sh_year;
  logic [12:0]                 yq4;

  assign up_ready = !valid_r || dn_ready;
  assign jan_feb  = (month <= gdi_pkg::MonthFeb);
  assign sh_year  = {1'b0, year} + 15'd400 - {14'd0, jan_feb};
  assign yq4      = sh_year[14:2];

  always_comb begin
    data_nxt       = '0;
    data_nxt.y     = sh_year;
    data_nxt.yq    = year[13:2];
    data_nxt.div4  = (year[1:0] == 2'd0);
    data_nxt.py    = {11'd0, yq4} * {13'd0, gdi_pkg::Recip25};
    data_nxt.pyr   = {11'd0, year[13:2]} * {12'd0, gdi_pkg::Recip25};
    data_nxt.month = month;
    data_nxt.day   = day;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### rtl/gdi_calendar.sv
// Stage 2: leap year, month length, validity and the weekday sum.
module gdi_calendar (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  gdi_pkg::s1_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output gdi_pkg::s2_t dn_data
);

  logic         valid_r;
  gdi_pkg::s2_t data_r;
  gdi_pkg::s2_t data_nxt;
  logic [8:0]   q100;
  logic [7:0]   k;
  logic [11:0]  k25;
  logic         cent;

  assign up_ready = !valid_r || dn_ready;

  assign q100 = up_data.py[gdi_pkg::RecipShift +: 9];
  assign k    = up_data.pyr[gdi_pkg::RecipShift +: 8];
  assign k25  = {k, 4'd0} + {1'b0, k, 3'd0} + {4'd0, k};
  // year is a whole century when it is divisible by 4 and (year >> 2) is a multiple of 25
  assign cent = up_data.div4 && (up_data.yq == k25);

  always_comb begin
    data_nxt         = '0;
    data_nxt.leap    = (up_data.div4 && !cent) || (cent && (k[1:0] == 2'd0));
    data_nxt.mlen    = gdi_pkg::month_len(up_data.month, data_nxt.leap);
    data_nxt.invalid = (data_nxt.mlen == 5'd0) || (up_data.day == 5'd0) ||
                       (up_data.day > data_nxt.mlen);
    data_nxt.s       = {10'd0, up_data.day} + up_data.y + {2'd0, up_data.y[14:2]}
                     - {6'd0, q100} + {8'd0, q100[8:2]}
                     + {10'd0, gdi_pkg::month_offset(up_data.month)};
    data_nxt.month   = up_data.month;
    data_nxt.day     = up_data.day;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### rtl/gdi_count.sv
// Stage 3: weekday mod 7 and the day counts to month end and year end.
module gdi_count (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  gdi_pkg::s2_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output gdi_pkg::s3_t dn_data
);

  logic         valid_r;
  gdi_pkg::s3_t data_r;
  gdi_pkg::s3_t data_nxt;
  logic [5:0]   fold1;
  logic [3:0]   fold2;
  logic [2:0]   fold3;
  logic [8:0]   doy;

  assign up_ready = !valid_r || dn_ready;

  // 8 is 1 mod 7: add octal digits until three bits remain
  assign fold1 = {3'd0, up_data.s[2:0]} + {3'd0, up_data.s[5:3]} + {3'd0, up_data.s[8:6]}
               + {3'd0, up_data.s[11:9]} + {3'd0, up_data.s[14:12]};
  assign fold2 = {1'b0, fold1[5:3]} + {1'b0, fold1[2:0]};
  assign fold3 = {2'd0, fold2[3]} + fold2[2:0];

  assign doy = gdi_pkg::days_before(up_data.month) + {4'd0, up_data.day}
             + {8'd0, up_data.leap && (up_data.month > gdi_pkg::MonthFeb)};

  always_comb begin
    data_nxt         = '0;
    data_nxt.leap    = up_data.leap;
    data_nxt.mlen    = up_data.mlen;
    data_nxt.invalid = up_data.invalid;
    if (!up_data.invalid) begin
      data_nxt.wd      = (fold3 == 3'd7) ? 3'd0 : fold3;
      data_nxt.to_mend = up_data.mlen - up_data.day + 5'd1;
      data_nxt.to_yend = 9'd366 + {8'd0, up_data.leap} - doy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### rtl/gregorian_date_info_unit.sv
// Gregorian date info unit: one date in, one result out, four register stages.
// out_tvalid rises once an item has passed the decode, calendar, count and output
// registers, and one item can enter every cycle unless the output stalls. Each
// stage holds while the one after it is full and stalled, so bubbles close up and
// in_tready follows out_tready through that ready chain. The weekday uses the
// closed Gregorian formula with Sunday as 0; the divisions by 100 and 400 are
// reciprocal multiplies in the first stage. For an invalid month or day, out_tuser
// is set and the weekday, weekend, days-to-Sunday and both day counts read zero;
// leap year and month length are still given.
`include "gregorian_date_info_unit_defines.svh"

module gregorian_date_info_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // year[13:0], month[17:14], day[22:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // weekday[2:0], is_weekend[3], days_to_sunday[6:4],
                                  // days_to_month_end[11:7], days_to_year_end[20:12],
                                  // leap_year[21], month_length[26:22]
  output logic [0:0]  out_tuser   // invalid_date[0]
);

  gdi_pkg::s1_t s1_data;
  gdi_pkg::s2_t s2_data;
  gdi_pkg::s3_t s3_data;
  logic         s1_valid, s2_valid, s3_valid;
  logic         s2_ready, s3_ready, s4_ready;

  logic         valid_r;
  logic [31:0]  tdata_r;
  logic [0:0]   tuser_r;
  logic [31:0]  tdata_nxt;
  logic         wkend;
  logic [2:0]   to_sun;

  gdi_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .year     (in_tdata[13:0]),
    .month    (in_tdata[17:14]),
    .day      (in_tdata[22:18]),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_data  (s1_data)
  );

  gdi_calendar u_calendar (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_data  (s2_data)
  );

  gdi_count u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s4_ready),
    .dn_data  (s3_data)
  );

  assign s4_ready = !valid_r || out_tready;

  // weekday is already zero for an invalid date, so days-to-Sunday follows it; weekend is masked
  assign wkend  = !s3_data.invalid && ((s3_data.wd == 3'd0) || (s3_data.wd == 3'd6));
  assign to_sun = (s3_data.wd == 3'd0) ? 3'd0 : 3'd7 - s3_data.wd;

  assign tdata_nxt = {5'd0, s3_data.mlen, s3_data.leap, s3_data.to_yend,
                      s3_data.to_mend, to_sun, wkend, s3_data.wd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s4_ready) begin
      valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      tdata_r <= tdata_nxt;
      tuser_r <= s3_data.invalid;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;

  `GDI_ASSERT_NOW(a_invalid_zeroed, out_tvalid && out_tuser[0], out_tdata[20:0] == 21'd0)
  `GDI_ASSERT_NOW(a_sunday_sum, out_tvalid && !out_tuser[0],
    ((out_tdata[2:0] == 3'd0) && (out_tdata[6:4] == 3'd0)) ||
    ({1'b0, out_tdata[2:0]} + {1'b0, out_tdata[6:4]} == 4'd7))
  `GDI_ASSERT_NOW(a_month_count, out_tvalid && !out_tuser[0],
    (out_tdata[11:7] != 5'd0) && (out_tdata[11:7] <= out_tdata[26:22]) &&
    ({4'd0, out_tdata[11:7]} <= out_tdata[20:12]))

endmodule

### tb/gregorian_date_info_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Gregorian date info unit: directed and random dates.
module gregorian_date_info_unit_tb;

  localparam int unsigned SUNDAY = 0;
  localparam int unsigned SATURDAY = 6;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned MONTH_JAN = 1;
  localparam int unsigned MONTH_FEB = 32'(gdi_pkg::MonthFeb);
  localparam int unsigned MONTH_DEC = 12;
  localparam int unsigned MONTH_FIELD_MAX = 2**gdi_pkg::MonthW - 1;
  localparam int unsigned DAY_FIELD_MAX = 2**gdi_pkg::DayW - 1;
  localparam int unsigned YEAR_FIELD_MAX = 2**gdi_pkg::YearW - 1;
  localparam int unsigned NOMINAL_YEAR_MAX = 9999;
  localparam int unsigned RANDOM_PER_PHASE = 530;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct packed {
    logic [2:0] weekday;
    logic       is_weekend;
    logic [2:0] days_to_sunday;
    logic [4:0] days_to_month_end;
    logic [8:0] days_to_year_end;
    logic       leap_year;
    logic [4:0] month_length;
    logic       invalid_date;
  } date_info_t;

  typedef struct {
    logic [23:0] date;
    date_info_t  info;
  } pending_date_t;

  class date_scoreboard;
    pending_date_t pending_q[$];
    int unsigned n_errors = 0;
    int unsigned n_checked = 0;
    int unsigned n_invalid = 0;
    int unsigned n_leap = 0;
    bit [6:0] weekdays_seen = '0;

    function bit is_leap(int unsigned yr);
      return (yr % 4 == 0 && yr % 100 != 0) || (yr % 400 == 0);
    endfunction

    function int unsigned days_in_month(int unsigned yr, int unsigned mo);
      if (mo < MONTH_JAN || mo > MONTH_DEC) return 0;
      if (mo == MONTH_FEB) return is_leap(yr) ? 29 : 28;
      if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
      return 31;
    endfunction

    function date_info_t date_info(int unsigned yr, int unsigned mo, int unsigned dy);
      date_info_t r;
      int unsigned mlen, doy, early, shy, shm, wsum, wd;
      r = '0;
      r.leap_year = is_leap(yr);
      mlen = days_in_month(yr, mo);
      r.month_length = 5'(mlen);
      r.invalid_date = (mlen == 0 || dy == 0 || dy > mlen);
      if (!r.invalid_date) begin
        doy = dy;
        for (int unsigned k = MONTH_JAN; k < mo; k++) doy += days_in_month(yr, k);
        // count Jan/Feb as months 11 and 12 of the year before; the 400-year
        // shift keeps January of year 0 positive without moving the weekday
        early = (mo <= MONTH_FEB) ? 1 : 0;
        shy = yr + 400 - early;
        shm = mo + 12 * early - 2;
        wsum = dy + shy + shy / 4 - shy / 100 + shy / 400 + (31 * shm) / 12;
        wd = wsum % DAYS_PER_WEEK;
        r.weekday = 3'(wd);
        r.is_weekend = (wd == SATURDAY || wd == SUNDAY);
        r.days_to_sunday = 3'((DAYS_PER_WEEK - wd) % DAYS_PER_WEEK);
        r.days_to_month_end = 5'(mlen - dy + 1);
        r.days_to_year_end = 9'(365 + 32'(r.leap_year) - doy + 1);
      end
      return r;
    endfunction

    task report(string what, logic [23:0] date, int unsigned got, int unsigned want);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("mismatch on %s for year %0d month %0d day %0d: got %0d, want %0d",
                 what, date[13:0], date[17:14], date[22:18], got, want);
    endtask

    function void note_date(logic [23:0] word);
      pending_date_t p;
      p.date = word;
      p.info = date_info(word[13:0], word[17:14], word[22:18]);
      pending_q.push_back(p);
    endfunction

    task check_result(logic [31:0] data, logic [0:0] user);
      pending_date_t p;
      if (pending_q.size() == 0) begin
        report("result with no date pending", '0, data, 0);
        return;
      end
      p = pending_q.pop_front();
      n_checked++;
      if (p.info.invalid_date) n_invalid++;
      else weekdays_seen[p.info.weekday] = 1'b1;
      if (p.info.leap_year) n_leap++;
      if (data[2:0] != p.info.weekday)
        report("weekday", p.date, data[2:0], p.info.weekday);
      if (data[3] != p.info.is_weekend)
        report("is_weekend", p.date, data[3], p.info.is_weekend);
      if (data[6:4] != p.info.days_to_sunday)
        report("days_to_sunday", p.date, data[6:4], p.info.days_to_sunday);
      if (data[11:7] != p.info.days_to_month_end)
        report("days_to_month_end", p.date, data[11:7], p.info.days_to_month_end);
      if (data[20:12] != p.info.days_to_year_end)
        report("days_to_year_end", p.date, data[20:12], p.info.days_to_year_end);
      if (data[21] != p.info.leap_year)
        report("leap_year", p.date, data[21], p.info.leap_year);
      if (data[26:22] != p.info.month_length)
        report("month_length", p.date, data[26:22], p.info.month_length);
      if (user[0] != p.info.invalid_date)
        report("invalid_date", p.date, user[0], p.info.invalid_date);
    endtask

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [23:0] in_tdata = '0;
  logic out_tready = 1'b0;
  logic in_tready;
  logic out_tvalid;
  logic [31:0] out_tdata;
  logic [0:0] out_tuser;

  int unsigned src_idle_pct = 18;
  int unsigned sink_idle_pct = 63;
  int unsigned quiet_cycles = 0;
  date_scoreboard sb;

  always #4 clk = ~clk;

  gregorian_date_info_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // note accepted dates, check results, and watch for a stuck stream
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_date(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_date(input int unsigned yr, input int unsigned mo, input int unsigned dy);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, 5'(dy), 4'(mo), 14'(yr)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_date();
    int unsigned yr, mo, dy, mlen, pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) yr = $urandom_range(0, YEAR_FIELD_MAX);
    else yr = $urandom_range(1, NOMINAL_YEAR_MAX);
    // century years exercise the 100 and 400 leap rules
    if (pick >= 30 && pick < 38) yr = 100 * $urandom_range(0, 99);
    mo = $urandom_range(MONTH_JAN, MONTH_DEC);
    mlen = sb.days_in_month(yr, mo);
    if (pick < 12) begin
      mo = $urandom_range(0, MONTH_FIELD_MAX);
      dy = $urandom_range(0, DAY_FIELD_MAX);
    end else if (pick < 30) begin
      case ($urandom_range(0, 2))
        0: dy = 1;
        1: dy = mlen;
        default: dy = mlen + 1;
      endcase
    end else begin
      dy = $urandom_range(1, mlen);
    end
    send_date(yr, mo, dy);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_date(1, MONTH_JAN, 1);
    send_date(NOMINAL_YEAR_MAX, MONTH_DEC, 31);
    send_date(YEAR_FIELD_MAX, MONTH_DEC, 31);
    send_date(0, MONTH_JAN, 1);
    send_date(0, MONTH_FEB, 29);
    send_date(0, 3, 1);
    send_date(2000, MONTH_FEB, 29);
    send_date(1900, MONTH_FEB, 29);
    send_date(1900, MONTH_FEB, 28);
    send_date(2024, MONTH_FEB, 29);
    send_date(2023, MONTH_FEB, 29);
    send_date(2024, MONTH_DEC, 31);
    send_date(2024, MONTH_JAN, 1);
    send_date(2023, MONTH_JAN, 1);
    send_date(2021, 0, 15);
    send_date(2021, 13, 1);
    send_date(2021, MONTH_FIELD_MAX, DAY_FIELD_MAX);
    send_date(2021, 4, 31);
    send_date(2021, 4, 30);
    send_date(2021, 7, 0);
    send_date(2021, 7, 31);
    send_date(YEAR_FIELD_MAX, MONTH_FIELD_MAX, DAY_FIELD_MAX);
    send_date(2024, 6, 8);
    send_date(2024, 6, 9);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 18;
          sink_idle_pct = 63;
        end
        1: begin
          src_idle_pct = 63;
          sink_idle_pct = 18;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_date();
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("dates left without a result", '0, sb.pending(), 0);

    $display("checked %0d results: %0d invalid dates, %0d in leap years, weekdays seen %b",
             sb.n_checked, sb.n_invalid, sb.n_leap, sb.weekdays_seen);
    $display("stalls on both sides in turn, then full rate; %0d mismatches", sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
